// ===== design/two_party_consensus_safety_fsm_macros.svh =====
// Assertion macros shared by the safety consensus design.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef TWO_PARTY_CONSENSUS_SAFETY_FSM_MACROS_SVH
`define TWO_PARTY_CONSENSUS_SAFETY_FSM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPCS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("safety consensus check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("safety consensus check failed");

`endif

// ===== design/tpcs_pkg.sv =====
package tpcs_pkg;

    localparam int ID_BITS       = 8;
    localparam int TIMER_BITS    = 12;
    localparam int TTC_BITS      = 14;
    localparam int ACT_BITS      = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = (ID_BITS > TIMER_BITS) ? ID_BITS : TIMER_BITS;

    localparam logic [TIMER_BITS-1:0] CONSENSUS_RESET  = TIMER_BITS'(150);
    localparam logic [TIMER_BITS-1:0] CLEAR_HOLD_RESET = TIMER_BITS'(1000);
    localparam logic [TIMER_BITS-1:0] RELAY_RESET      = TIMER_BITS'(250);
    localparam logic [TTC_BITS-1:0]   TTC_MAX          = TTC_BITS'(10000);

    // Action codes.
    localparam logic [ACT_BITS-1:0] ACT_BRAKE   = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_RIGHT   = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_LEFT    = 2'd2;
    localparam logic [ACT_BITS-1:0] ACT_INVALID = 2'd3;
    localparam logic [ACT_BITS-1:0] ACT_ESTOP   = 2'd3;

    typedef enum logic [1:0] {
        OP_ASSESS    = 2'd0,
        OP_PEER      = 2'd1,
        OP_TICK      = 2'd2,
        OP_SENT_DONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        M_MON  = 2'd0,
        M_PROP = 2'd1,
        M_EXEC = 2'd2,
        M_STOP = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_EXEC = 2'd1,
        EV_STOP = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        RSN_MATCH       = 2'd0,
        RSN_TIMEOUT     = 2'd1,
        RSN_TIMEOUT_NOK = 2'd2
    } t_reason;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOCAL_ID    = 2'd0,
        CFG_CONSENSUS   = 2'd1,
        CFG_CLEAR_HOLD  = 2'd2,
        CFG_RELAY       = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_op                  operation;
        logic                 collision;
        logic [ID_BITS-1:0]   first_car;
        logic [ID_BITS-1:0]   second_car;
        logic [ACT_BITS-1:0]  first_action;
        logic [ACT_BITS-1:0]  second_action;
        logic [TTC_BITS-1:0]  collision_time_ms;
        logic [ID_BITS-1:0]   sender_car;
        logic                 send_ok;
    } t_in_item;

    typedef struct packed {
        t_event               event_kind;
        logic [ACT_BITS-1:0]  vehicle_action;
        logic [TTC_BITS-1:0]  event_time_ms;
        t_reason              event_reason;
        t_mode                safety_mode;
        logic                 proposal_due;
        logic                 execution_due;
    } t_out_item;

endpackage

// ===== design/two_party_consensus_safety_fsm.sv =====
// Two-party consensus safety machine.
// Items arrive on the input channel (i_in_valid, o_in_stall, i_in_item) and every
// accepted item gives exactly one result item on the output channel
// (o_out_valid, i_out_stall, o_out_item). An item is taken at a rising edge where
// valid is high and stall is low.
// An accepted item is held in the input register, is evaluated against
// the machine state by a single pass of compare and counter logic, and its result
// is captured in the output register together with the new state once the
// evaluation stage advances. Each item passes through the input register and then
// the output register, and one item can be taken in every cycle, limited only by
// the output register draining.
// When the receiver stalls, the output register holds its result and the input
// register keeps one further item; the input channel stalls only once both are
// full. Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_wdata, and must only be written while no item is in flight.
// Reset (synchronous, active low) returns the machine to monitoring with no
// pending proposal, clears both channel registers and loads the default timeout,
// clear-hold and relay-window settings.
module two_party_consensus_safety_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tpcs_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tpcs_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [tpcs_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [tpcs_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata
);

`include "two_party_consensus_safety_fsm_macros.svh"

    // Configuration registers.
    logic [tpcs_pkg::ID_BITS-1:0]    r_local_car_id;
    logic [tpcs_pkg::TIMER_BITS-1:0] r_consensus_ticks;
    logic [tpcs_pkg::TIMER_BITS-1:0] r_clear_hold_ticks;
    logic [tpcs_pkg::TIMER_BITS-1:0] r_relay_ticks;

    // Channel registers.
    logic                 r_in_valid;
    tpcs_pkg::t_in_item   r_in;
    logic                 r_out_valid;
    tpcs_pkg::t_out_item  r_out;
    tpcs_pkg::t_out_item  n_out;

    // Machine state and its next value.
    tpcs_pkg::t_mode                 r_mode, n_mode;
    logic                            r_pending_valid, n_pending_valid;
    logic                            r_proposal_sent, n_proposal_sent;
    logic [tpcs_pkg::ID_BITS-1:0]    r_pending_first, n_pending_first;
    logic [tpcs_pkg::ID_BITS-1:0]    r_pending_second, n_pending_second;
    logic [2*tpcs_pkg::ACT_BITS-1:0] r_pending_actions, n_pending_actions;
    logic [tpcs_pkg::TTC_BITS-1:0]   r_pending_time, n_pending_time;
    logic [tpcs_pkg::TIMER_BITS-1:0] r_deadline_left, n_deadline_left;
    logic [tpcs_pkg::TIMER_BITS-1:0] r_relay_left, n_relay_left;
    logic                            r_clear_active, n_clear_active;
    logic [tpcs_pkg::TIMER_BITS-1:0] r_clear_elapsed, n_clear_elapsed;
    logic [tpcs_pkg::ACT_BITS-1:0]   r_committed, n_committed;

    // The evaluation stage moves forward unless a finished result is still held
    // by a stalling receiver.
    logic w_advance;
    logic w_in_take;

    assign w_advance   = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Configuration writes. Data above a register's width is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_car_id     <= '0;
            r_consensus_ticks  <= tpcs_pkg::CONSENSUS_RESET;
            r_clear_hold_ticks <= tpcs_pkg::CLEAR_HOLD_RESET;
            r_relay_ticks      <= tpcs_pkg::RELAY_RESET;
        end else if (i_cfg_we) begin
            case (tpcs_pkg::t_cfg_reg'(i_cfg_index))
                tpcs_pkg::CFG_LOCAL_ID: begin
                    r_local_car_id <= i_cfg_wdata[tpcs_pkg::ID_BITS-1:0];
                end
                tpcs_pkg::CFG_CONSENSUS: begin
                    r_consensus_ticks <= i_cfg_wdata[tpcs_pkg::TIMER_BITS-1:0];
                end
                tpcs_pkg::CFG_CLEAR_HOLD: begin
                    r_clear_hold_ticks <= i_cfg_wdata[tpcs_pkg::TIMER_BITS-1:0];
                end
                tpcs_pkg::CFG_RELAY: begin
                    r_relay_ticks <= i_cfg_wdata[tpcs_pkg::TIMER_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_take || (r_in_valid && !w_advance);
        end
        if (w_in_take) begin
            r_in <= i_in_item;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // State register: it moves only when an item is evaluated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= tpcs_pkg::M_MON;
            r_pending_valid   <= 1'b0;
            r_proposal_sent   <= 1'b0;
            r_pending_first   <= '0;
            r_pending_second  <= '0;
            r_pending_actions <= '0;
            r_pending_time    <= '0;
            r_deadline_left   <= '0;
            r_relay_left      <= '0;
            r_clear_active    <= 1'b0;
            r_clear_elapsed   <= '0;
            r_committed       <= '0;
        end else if (w_advance) begin
            r_mode            <= n_mode;
            r_pending_valid   <= n_pending_valid;
            r_proposal_sent   <= n_proposal_sent;
            r_pending_first   <= n_pending_first;
            r_pending_second  <= n_pending_second;
            r_pending_actions <= n_pending_actions;
            r_pending_time    <= n_pending_time;
            r_deadline_left   <= n_deadline_left;
            r_relay_left      <= n_relay_left;
            r_clear_active    <= n_clear_active;
            r_clear_elapsed   <= n_clear_elapsed;
            r_committed       <= n_committed;
        end
    end

    // Single evaluation pass for the item in the input register. The statements
    // follow one another as the machine reacts: first the item itself, then the
    // deadline check, then the end of the relay window.
    always_comb begin
        logic                            bad_act;
        logic [2*tpcs_pkg::ACT_BITS-1:0] acts;
        logic [tpcs_pkg::TTC_BITS-1:0]   ttc;
        logic                            local_first;
        logic [tpcs_pkg::ID_BITS-1:0]    peer_id;
        logic                            due;

        n_mode            = r_mode;
        n_pending_valid   = r_pending_valid;
        n_proposal_sent   = r_proposal_sent;
        n_pending_first   = r_pending_first;
        n_pending_second  = r_pending_second;
        n_pending_actions = r_pending_actions;
        n_pending_time    = r_pending_time;
        n_deadline_left   = r_deadline_left;
        n_relay_left      = r_relay_left;
        n_clear_active    = r_clear_active;
        n_clear_elapsed   = r_clear_elapsed;
        n_committed       = r_committed;

        n_out = '0;
        n_out.event_kind   = tpcs_pkg::EV_NONE;
        n_out.event_reason = tpcs_pkg::RSN_MATCH;

        bad_act = (r_in.first_action == tpcs_pkg::ACT_INVALID) ||
                  (r_in.second_action == tpcs_pkg::ACT_INVALID);
        acts    = {r_in.second_action, r_in.first_action};
        ttc     = (r_in.collision_time_ms > tpcs_pkg::TTC_MAX) ?
                  tpcs_pkg::TTC_MAX : r_in.collision_time_ms;
        local_first = (r_pending_first == r_local_car_id);
        peer_id     = local_first ? r_pending_second : r_pending_first;
        due = r_pending_valid && ((r_mode == tpcs_pkg::M_PROP) ||
              ((r_mode == tpcs_pkg::M_EXEC) && (r_relay_left != '0)));

        case (r_in.operation)
            tpcs_pkg::OP_ASSESS: begin
                if (!(r_in.collision && bad_act)) begin
                    if ((r_mode == tpcs_pkg::M_EXEC) || (r_mode == tpcs_pkg::M_STOP)) begin
                        // Counting clear time before standing down.
                        if (r_in.collision) begin
                            n_clear_active = 1'b0;
                        end else if (!r_clear_active) begin
                            n_clear_active  = 1'b1;
                            n_clear_elapsed = '0;
                        end else if (r_clear_elapsed >= r_clear_hold_ticks) begin
                            n_mode          = tpcs_pkg::M_MON;
                            n_pending_valid = 1'b0;
                            n_proposal_sent = 1'b0;
                            n_committed     = tpcs_pkg::ACT_BRAKE;
                            n_clear_active  = 1'b0;
                        end
                    end else if ((r_mode == tpcs_pkg::M_PROP) && r_pending_valid) begin
                        // A proposal is already out; new assessments wait.
                    end else if (!r_in.collision) begin
                        n_mode          = tpcs_pkg::M_MON;
                        n_pending_valid = 1'b0;
                        n_proposal_sent = 1'b0;
                    end else if (!r_pending_valid || (r_pending_first != r_in.first_car) ||
                                 (r_pending_second != r_in.second_car) ||
                                 (r_pending_actions != acts)) begin
                        n_pending_first   = r_in.first_car;
                        n_pending_second  = r_in.second_car;
                        n_pending_actions = acts;
                        n_pending_time    = ttc;
                        n_pending_valid   = 1'b1;
                        n_proposal_sent   = 1'b0;
                        n_deadline_left   = r_consensus_ticks;
                        n_mode            = tpcs_pkg::M_PROP;
                    end
                end
            end
            tpcs_pkg::OP_PEER: begin
                if (!bad_act && (r_in.sender_car != r_local_car_id) &&
                    (r_mode == tpcs_pkg::M_PROP) && r_pending_valid) begin
                    if (r_deadline_left == '0) begin
                        // The peer answered too late.
                        n_mode                = tpcs_pkg::M_STOP;
                        n_committed           = tpcs_pkg::ACT_ESTOP;
                        n_clear_active        = 1'b0;
                        n_pending_valid       = 1'b0;
                        n_proposal_sent       = 1'b0;
                        n_out.event_kind      = tpcs_pkg::EV_STOP;
                        n_out.vehicle_action  = tpcs_pkg::ACT_ESTOP;
                        n_out.event_time_ms   = r_pending_time;
                        n_out.event_reason    = tpcs_pkg::RSN_TIMEOUT;
                    end else if ((r_in.sender_car == peer_id) &&
                                 (acts == r_pending_actions) && r_in.send_ok) begin
                        n_proposal_sent       = 1'b1;
                        n_mode                = tpcs_pkg::M_EXEC;
                        n_committed           = local_first ?
                                                r_pending_actions[1:0] :
                                                r_pending_actions[3:2];
                        n_clear_active        = 1'b0;
                        n_relay_left          = r_relay_ticks;
                        n_out.event_kind      = tpcs_pkg::EV_EXEC;
                        n_out.vehicle_action  = n_committed;
                        n_out.event_time_ms   = r_pending_time;
                        n_out.event_reason    = tpcs_pkg::RSN_MATCH;
                    end
                end
            end
            tpcs_pkg::OP_TICK: begin
                if (r_deadline_left != '0) begin
                    n_deadline_left = r_deadline_left - 1'b1;
                end
                if (r_relay_left != '0) begin
                    n_relay_left = r_relay_left - 1'b1;
                end
                if (r_clear_active && (r_clear_elapsed != '1)) begin
                    n_clear_elapsed = r_clear_elapsed + 1'b1;
                end
            end
            tpcs_pkg::OP_SENT_DONE: begin
                if (r_in.send_ok && due) begin
                    n_proposal_sent = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Deadline check after any item that raised no event.
        if ((n_out.event_kind == tpcs_pkg::EV_NONE) && (n_mode == tpcs_pkg::M_PROP) &&
            n_pending_valid && (n_deadline_left == '0)) begin
            n_out.event_kind     = tpcs_pkg::EV_STOP;
            n_out.vehicle_action = tpcs_pkg::ACT_ESTOP;
            n_out.event_time_ms  = n_pending_time;
            n_out.event_reason   = n_proposal_sent ? tpcs_pkg::RSN_TIMEOUT :
                                                     tpcs_pkg::RSN_TIMEOUT_NOK;
            n_mode              = tpcs_pkg::M_STOP;
            n_committed         = tpcs_pkg::ACT_ESTOP;
            n_clear_active      = 1'b0;
            n_pending_valid     = 1'b0;
            n_proposal_sent     = 1'b0;
        end

        // Relaying stops once the window after a commit has run out.
        if ((n_mode == tpcs_pkg::M_EXEC) && n_pending_valid && (n_relay_left == '0)) begin
            n_pending_valid = 1'b0;
        end

        n_out.safety_mode   = n_mode;
        n_out.proposal_due  = n_pending_valid && ((n_mode == tpcs_pkg::M_PROP) ||
                              ((n_mode == tpcs_pkg::M_EXEC) && (n_relay_left != '0)));
        n_out.execution_due = (n_mode == tpcs_pkg::M_EXEC) || (n_mode == tpcs_pkg::M_STOP);
    end

    // Proposing always has a proposal behind it.
    `TPCS_ASSERT_SAME(a_prop_has_pending, r_mode == tpcs_pkg::M_PROP, r_pending_valid)

    // The held result reports the mode that the state register now holds.
    `TPCS_ASSERT_SAME(a_out_mode_matches, r_out_valid, r_out.safety_mode == r_mode)

    // A commit to execute is reported only together with the execute mode.
    `TPCS_ASSERT_SAME(a_exec_event_mode,
        r_out_valid && (r_out.event_kind == tpcs_pkg::EV_EXEC),
        (r_out.safety_mode == tpcs_pkg::M_EXEC) && r_out.execution_due)

    // An emergency stop event always carries the stop action.
    `TPCS_ASSERT_SAME(a_stop_event_action,
        r_out_valid && (r_out.event_kind == tpcs_pkg::EV_STOP),
        (r_out.vehicle_action == tpcs_pkg::ACT_ESTOP) && (r_out.safety_mode == tpcs_pkg::M_STOP))

    // An item that can move on always lands in the output register.
    `TPCS_ASSERT_NEXT(a_advance_fills_out, w_advance, r_out_valid)

endmodule
